FILE: sv/sob_pkg.sv
// Shared types and constants for the RGBA8 source-over blender.
package sob_pkg;

  localparam logic [7:0] CHAN_MAX  = 8'd255;
  localparam int         DIV_STEPS = 8;
  localparam int         NUM_CHAN  = 3;

  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } blend_t;

  // After the first multiply: source colour times source alpha, and the
  // destination weight da*(255-sa).
  typedef struct packed {
    logic [7:0]                   sa;
    logic [7:0]                   da;
    logic [NUM_CHAN-1:0][15:0]    src_wt;
    logic [NUM_CHAN-1:0][7:0]     dst;
    logic [15:0]                  dst_wt;
  } prod_word_t;

  // Word moving along the divider cells.
  typedef struct packed {
    logic [15:0]                  divisor;
    logic [7:0]                   alpha;
    logic [NUM_CHAN-1:0][23:0]    rem;
    logic [NUM_CHAN-1:0][7:0]     quo;
  } div_word_t;

endpackage

FILE: sv/rgba8_source_over_blend.sv
// Top level of the RGBA8 source-over blender: product, sum and divider cells.
//
// Input channel pixel/pixel_valid/pixel_ready carries one source and one
// destination RGBA8 pixel with straight alpha; output channel
// blend/blend_valid/blend_ready carries the composite pixel.
// The word passes a chain of ten registered cells: one multiply cell, one
// sum cell that forms the combined alpha and the colour numerators, and
// eight divider cells, each settling one quotient bit for all three colour
// lanes. Throughput is one pixel per clock while blend_ready is held high;
// each cell holds one word and passes it on every cycle that its neighbour
// can take it. When the receiver stalls, words pile up in the cells;
// pixel_ready drops only once every cell holds a word, so bubbles in the
// chain are absorbed.
// Reset (rst, synchronous) empties every cell; no other state is kept.
module rgba8_source_over_blend
  import sob_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  output logic   pixel_ready,
  input  pixel_t pixel,
  output logic   blend_valid,
  input  logic   blend_ready,
  output blend_t blend
);

  logic       prod_valid;
  logic       prod_ready;
  prod_word_t prod_data;

  logic       chain_valid [DIV_STEPS+1];
  logic       chain_ready [DIV_STEPS+1];
  div_word_t  chain_data  [DIV_STEPS+1];

  sob_prod_cell u_prod (
    .clk      (clk),
    .rst      (rst),
    .up_valid (pixel_valid),
    .up_ready (pixel_ready),
    .up_data  (pixel),
    .dn_valid (prod_valid),
    .dn_ready (prod_ready),
    .dn_data  (prod_data)
  );

  sob_sum_cell u_sum (
    .clk      (clk),
    .rst      (rst),
    .up_valid (prod_valid),
    .up_ready (prod_ready),
    .up_data  (prod_data),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_data  (chain_data[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    sob_div_cell #(
      .BIT (DIV_STEPS - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_data  (chain_data[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_data  (chain_data[i+1])
    );
  end

  assign blend_valid              = chain_valid[DIV_STEPS];
  assign chain_ready[DIV_STEPS]   = blend_ready;
  assign blend.out_red            = chain_data[DIV_STEPS].quo[0];
  assign blend.out_green          = chain_data[DIV_STEPS].quo[1];
  assign blend.out_blue           = chain_data[DIV_STEPS].quo[2];
  assign blend.out_alpha          = chain_data[DIV_STEPS].alpha;

endmodule

FILE: sv/sob_prod_cell.sv
// First cell: colour-by-alpha and destination-weight products.
module sob_prod_cell
  import sob_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  output logic       up_ready,
  input  pixel_t     up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output prod_word_t dn_data
);

  prod_word_t word_next;
  logic [7:0] sa_inv;

  always_comb begin
    sa_inv             = CHAN_MAX - up_data.src_alpha;
    word_next.sa       = up_data.src_alpha;
    word_next.da       = up_data.dst_alpha;
    word_next.src_wt[0] = up_data.src_red   * up_data.src_alpha;
    word_next.src_wt[1] = up_data.src_green * up_data.src_alpha;
    word_next.src_wt[2] = up_data.src_blue  * up_data.src_alpha;
    word_next.dst[0]   = up_data.dst_red;
    word_next.dst[1]   = up_data.dst_green;
    word_next.dst[2]   = up_data.dst_blue;
    word_next.dst_wt   = up_data.dst_alpha * sa_inv;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= word_next;
    end
  end

endmodule

FILE: sv/sob_sum_cell.sv
// Second cell: combined alpha, numerators and divider set-up.
module sob_sum_cell
  import sob_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  output logic       up_ready,
  input  prod_word_t up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output div_word_t  dn_data
);

  div_word_t   word_next;
  logic [16:0] total;
  logic [16:0] alpha_sum;
  logic [24:0] numer [NUM_CHAN];
  logic        pass_dst;

  always_comb begin
    // A transparent source hands the destination straight through: a unit
    // divisor with zero remainder sets no quotient bits.
    pass_dst  = (up_data.sa == '0);
    total     = {1'b0, up_data.sa, 8'd0} - 17'(up_data.sa) + 17'(up_data.dst_wt);
    // Exact divide by 255 for any total up to 255*255.
    alpha_sum = {1'b0, total[15:0]} + 17'd1 + 17'(total[15:8]);
    for (int k = 0; k < NUM_CHAN; k++) begin
      numer[k] = {1'b0, up_data.src_wt[k], 8'd0} - 25'(up_data.src_wt[k])
               + 25'(up_data.dst[k]) * 25'(up_data.dst_wt);
    end
    word_next.divisor = pass_dst ? 16'd1 : total[15:0];
    word_next.alpha   = pass_dst ? up_data.da : alpha_sum[15:8];
    for (int k = 0; k < NUM_CHAN; k++) begin
      word_next.rem[k] = pass_dst ? 24'd0 : numer[k][23:0];
      word_next.quo[k] = pass_dst ? up_data.dst[k] : 8'd0;
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= word_next;
    end
  end

endmodule

FILE: sv/sob_div_cell.sv
// Divider cell: one restoring-division quotient bit for each colour lane.
module sob_div_cell
  import sob_pkg::*;
#(
  parameter int BIT = 7
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  output logic      up_ready,
  input  div_word_t up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output div_word_t dn_data
);

  div_word_t   word_next;
  logic [24:0] shifted;
  logic [24:0] diff [NUM_CHAN];

  always_comb begin
    word_next = up_data;
    shifted   = 25'(up_data.divisor) << BIT;
    for (int k = 0; k < NUM_CHAN; k++) begin
      diff[k] = {1'b0, up_data.rem[k]} - shifted;
      // no borrow: keep the reduced remainder and set this quotient bit
      if (!diff[k][24]) begin
        word_next.rem[k]      = diff[k][23:0];
        word_next.quo[k][BIT] = 1'b1;
      end
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= word_next;
    end
  end

endmodule
